// File: design/dccenc_pkg.sv
package dccenc_pkg;

  localparam int unsigned MaxFrames = 16;
  localparam int unsigned FrameBits = 38;
  localparam int unsigned SlotW     = $clog2(MaxFrames);
  localparam int unsigned IdxW      = $clog2(MaxFrames + 1);
  localparam int unsigned PosW      = $clog2(FrameBits);

  localparam logic [FrameBits-1:0] IdleFrame = 38'h3FF7F801FF;
  localparam logic [IdxW-1:0]      IdleIdx   = IdxW'(MaxFrames);
  localparam logic [PosW-1:0]      LastPos   = PosW'(FrameBits - 1);

  typedef enum logic [1:0] {
    KIND_TICK      = 2'd0,
    KIND_WRITE     = 2'd1,
    KIND_COPY_DONE = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e                kind;
    logic [SlotW-1:0]     slot;
    logic [FrameBits-1:0] frame_word;
  } in_item_t;

  typedef struct packed {
    logic            track_level;
    logic            copy_window;
    logic [IdxW-1:0] current_frame;
  } out_item_t;

  typedef struct packed {
    logic                 we;
    logic [SlotW-1:0]     slot;
    logic [FrameBits-1:0] word;
  } slot_wr_t;

endpackage

// File: design/dccenc_frame_store.sv
module dccenc_frame_store (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  dccenc_pkg::slot_wr_t           wr_i,
  input  logic [dccenc_pkg::IdxW-1:0]    rd_idx_i,
  output logic [dccenc_pkg::FrameBits-1:0] rd_word_o
);
  import dccenc_pkg::*;

  logic [FrameBits-1:0] slots_q [MaxFrames];
  logic [MaxFrames-1:0] valid_q;
  logic [SlotW-1:0]     rd_slot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.we) begin
      valid_q[wr_i.slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      slots_q[wr_i.slot] <= wr_i.word;
    end
  end

  assign rd_slot = rd_idx_i[SlotW-1:0];

  always_comb begin
    if (rd_idx_i >= IdleIdx || !valid_q[rd_slot]) begin
      rd_word_o = IdleFrame;
    end else begin
      rd_word_o = slots_q[rd_slot];
    end
  end

endmodule

// File: design/dccenc_bit_engine.sv
module dccenc_bit_engine (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             step_i,
  input  dccenc_pkg::in_item_t             item_i,
  input  logic [4:0]                       num_frames_i,
  input  logic [dccenc_pkg::FrameBits-1:0] rd_word_i,
  output logic [dccenc_pkg::IdxW-1:0]      rd_idx_o,
  output dccenc_pkg::slot_wr_t             wr_o,
  output dccenc_pkg::out_item_t            res_o
);
  import dccenc_pkg::*;

  logic [PosW-1:0] pos_q, pos_d;
  logic [1:0]      ticks_q, ticks_d;
  logic            level_q, level_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            idle_q, idle_d;
  logic            cf_q, cf_d;
  logic [IdxW:0]   frame_cnt;
  logic [IdxW:0]   idx_inc;
  logic [1:0]      ticks_new;

  always_comb begin
    if (num_frames_i == '0) begin
      frame_cnt = (IdxW+1)'(1);
    end else if ({1'b0, num_frames_i} > (IdxW+1)'(MaxFrames)) begin
      frame_cnt = (IdxW+1)'(MaxFrames);
    end else begin
      frame_cnt = (IdxW+1)'(num_frames_i);
    end
  end

  assign idx_inc   = {1'b0, idx_q} + (IdxW+1)'(1);
  assign ticks_new = rd_word_i[pos_q] ? 2'd1 : 2'd2;
  assign rd_idx_o  = idx_q;

  always_comb begin
    pos_d   = pos_q;
    ticks_d = ticks_q;
    level_d = level_q;
    idx_d   = idx_q;
    idle_d  = idle_q;
    cf_d    = cf_q;
    wr_o    = '{we: 1'b0, slot: item_i.slot, word: item_i.frame_word};
    if (step_i) begin
      unique case (item_i.kind)
        KIND_TICK: begin
          if (ticks_q == 2'd0) begin
            ticks_d = ticks_new - 2'd1;
            if (!level_q) begin
              level_d = 1'b1;
            end else begin
              level_d = 1'b0;
              if (pos_q == '0) begin
                pos_d = LastPos;
                if (idle_q) begin
                  if (cf_q) begin
                    idle_d = 1'b0;
                    cf_d   = 1'b0;
                    idx_d  = '0;
                  end
                end else if (idx_inc >= frame_cnt) begin
                  idle_d = 1'b1;
                  idx_d  = IdleIdx;
                end else begin
                  idx_d = idx_inc[IdxW-1:0];
                end
              end else begin
                pos_d = pos_q - PosW'(1);
              end
            end
          end else begin
            ticks_d = ticks_q - 2'd1;
          end
        end
        KIND_WRITE: begin
          wr_o.we = 1'b1;
        end
        KIND_COPY_DONE: begin
          if (idle_q) begin
            cf_d = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign res_o = '{track_level: level_d, copy_window: idle_d, current_frame: idx_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= LastPos;
      ticks_q <= '0;
      level_q <= 1'b0;
      idx_q   <= '0;
      idle_q  <= 1'b0;
      cf_q    <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      ticks_q <= ticks_d;
      level_q <= level_d;
      idx_q   <= idx_d;
      idle_q  <= idle_d;
      cf_q    <= cf_d;
    end
  end

endmodule

// File: design/dcc_track_bit_encoder_core.sv
// DCC track bit encoder. Each input transaction is a tick of one 58 us half
// period, a write of a frame slot, or a copy-done notice. Every transaction
// yields exactly one output transaction with the H-bridge level, the copy
// window flag and the index of the frame being sent (16 is the idle frame).
// Both channels use valid and ready. An input transaction is held in an input
// register, then the encoder logic updates its state and the result is held
// in an output register, and one transaction can be accepted in every cycle
// while the receiver does not stall. When the receiver stalls, the output
// register holds its result, the input register fills, and in_ready_o drops
// until out_ready_i returns. The frame count register is written through
// cfg_we_i and cfg_wdata_i and should only change while no transaction is in
// flight. Reset clears both registers, makes every slot read as the idle
// frame, sets the frame count to one and restarts at frame zero, bit 37, with
// the level low. No clearing pass is needed after reset.
module dcc_track_bit_encoder_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  dccenc_pkg::in_item_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output dccenc_pkg::out_item_t out_data_o,
  input  logic                  cfg_we_i,
  input  logic [4:0]            cfg_wdata_i
);
  import dccenc_pkg::*;

  logic                 in_valid_q;
  in_item_t             in_item_q;
  logic                 out_valid_q;
  out_item_t            out_item_q;
  logic [4:0]           num_frames_q;
  logic                 out_free;
  logic                 advance;
  logic [IdxW-1:0]      rd_idx;
  logic [FrameBits-1:0] rd_word;
  slot_wr_t             slot_wr;
  out_item_t            res;

  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      num_frames_q <= 5'd1;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
      if (cfg_we_i) begin
        num_frames_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_item_q <= in_data_i;
    end
    if (advance) begin
      out_item_q <= res;
    end
  end

  dccenc_bit_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .item_i       (in_item_q),
    .num_frames_i (num_frames_q),
    .rd_word_i    (rd_word),
    .rd_idx_o     (rd_idx),
    .wr_o         (slot_wr),
    .res_o        (res)
  );

  dccenc_frame_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (slot_wr),
    .rd_idx_i  (rd_idx),
    .rd_word_o (rd_word)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

endmodule

// File: design/dccenc_checker.sv
module dccenc_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input dccenc_pkg::out_item_t out_data_o
);
  import dccenc_pkg::*;

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("Stalled output transaction changed.");

  a_frame_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.current_frame <= IdleIdx)
    else $error("Frame index out of range.");

  a_window_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.copy_window == (out_data_o.current_frame == IdleIdx))
    else $error("Copy window does not match the idle frame.");

  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("Input stalled without an output stall.");

endmodule

bind dcc_track_bit_encoder_core dccenc_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
